FILE: rtl/wbps_pkg.sv
package wbps_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int PAT_W       = 8 * MAX_PATTERN;
  localparam int ADDR_W      = 6;
  localparam int DATA_W      = 64;
  localparam int POS_W       = 32;

  // Register indexes, taken from paddr[5:3].
  localparam logic [2:0] REG_PATTERN_LENGTH  = 3'd0;
  localparam logic [2:0] REG_PATTERN_LOW     = 3'd1;
  localparam logic [2:0] REG_PATTERN_HIGH    = 3'd2;
  localparam logic [2:0] REG_WILDCARD_ENABLE = 3'd3;
  localparam logic [2:0] REG_WILDCARD_BYTE   = 3'd4;
  localparam logic [2:0] REG_START_OFFSET    = 3'd5;
  localparam logic [2:0] REG_OCCURRENCE      = 3'd6;

  typedef struct packed {
    logic [4:0]       pattern_length;
    logic [PAT_W-1:0] pattern;
    logic             wildcard_enable;
    logic [7:0]       wildcard_byte;
    logic [POS_W-1:0] start_offset;
    logic [POS_W-1:0] occurrence;
  } cfg_t;

  // Effective pattern length minus one: zero acts as one, long values clamp.
  function automatic logic [IDX_W-1:0] eff_len_m1(input logic [4:0] len);
    logic [IDX_W-1:0] r;
    if (len == 5'd0) begin
      r = '0;
    end else if (len > 5'(MAX_PATTERN)) begin
      r = IDX_W'(MAX_PATTERN - 1);
    end else begin
      r = IDX_W'(len - 5'd1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/wbps_regs.sv
module wbps_regs import wbps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [4:0]       pattern_length_q;
  logic [63:0]      pattern_low_q;
  logic [63:0]      pattern_high_q;
  logic             wildcard_enable_q;
  logic [7:0]       wildcard_byte_q;
  logic [POS_W-1:0] start_offset_q;
  logic [POS_W-1:0] occurrence_q;
  logic [2:0]       reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_length_q  <= 5'd1;
      pattern_low_q     <= '0;
      pattern_high_q    <= '0;
      wildcard_enable_q <= 1'b0;
      wildcard_byte_q   <= '0;
      start_offset_q    <= '0;
      occurrence_q      <= POS_W'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PATTERN_LENGTH:  pattern_length_q  <= pwdata[4:0];
        REG_PATTERN_LOW:     pattern_low_q     <= pwdata;
        REG_PATTERN_HIGH:    pattern_high_q    <= pwdata;
        REG_WILDCARD_ENABLE: wildcard_enable_q <= pwdata[0];
        REG_WILDCARD_BYTE:   wildcard_byte_q   <= pwdata[7:0];
        REG_START_OFFSET:    start_offset_q    <= pwdata[POS_W-1:0];
        REG_OCCURRENCE:      occurrence_q      <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PATTERN_LENGTH:  prdata = DATA_W'(pattern_length_q);
      REG_PATTERN_LOW:     prdata = pattern_low_q;
      REG_PATTERN_HIGH:    prdata = pattern_high_q;
      REG_WILDCARD_ENABLE: prdata = DATA_W'(wildcard_enable_q);
      REG_WILDCARD_BYTE:   prdata = DATA_W'(wildcard_byte_q);
      REG_START_OFFSET:    prdata = DATA_W'(start_offset_q);
      REG_OCCURRENCE:      prdata = DATA_W'(occurrence_q);
      default:             prdata = '0;
    endcase
  end

  assign cfg_o.pattern_length  = pattern_length_q;
  assign cfg_o.pattern         = {pattern_high_q, pattern_low_q};
  assign cfg_o.wildcard_enable = wildcard_enable_q;
  assign cfg_o.wildcard_byte   = wildcard_byte_q;
  assign cfg_o.start_offset    = start_offset_q;
  assign cfg_o.occurrence      = occurrence_q;

endmodule

FILE: rtl/wbps_core.sv
module wbps_core import wbps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             fire_i,
  input  logic [7:0]       data_i,
  input  logic             last_i,
  input  logic             out_stall_i,
  output logic             advance_o,
  output logic             out_valid_o,
  output logic             found_o,
  output logic [POS_W-1:0] position_o
);

  // The stored window keeps the older bytes; the newest byte comes from data_i.
  logic [7:0]       win_q   [MAX_PATTERN-1];
  logic [7:0]       win_new [MAX_PATTERN];
  logic [POS_W-1:0] byte_index_q;
  logic [POS_W-1:0] match_count_q;
  logic             reported_q;
  logic             out_valid_q;
  logic             found_q;
  logic [POS_W-1:0] position_q;

  logic [IDX_W-1:0]       len_m1;
  logic [MAX_PATTERN-1:0] len_hit;
  logic                   window_match;
  logic                   window_full;
  logic [POS_W-1:0]       start_pos;
  logic                   counted;
  logic [POS_W-1:0]       count_inc;
  logic [POS_W-1:0]       want;
  logic                   hit;
  logic                   emit;
  logic [POS_W-1:0]       index_inc;

  always_comb begin
    win_new[0] = data_i;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_new[k] = win_q[k-1];
    end
  end

  // One compare result per possible pattern length, each at fixed taps;
  // the configured length then picks one of them.
  always_comb begin
    logic [7:0] p;
    logic       ok;
    for (int l = 0; l < MAX_PATTERN; l++) begin
      len_hit[l] = 1'b1;
      for (int j = 0; j <= l; j++) begin
        p  = cfg_i.pattern[8*j +: 8];
        ok = (cfg_i.wildcard_enable && (p == cfg_i.wildcard_byte)) ||
             (p == win_new[l-j]);
        len_hit[l] = len_hit[l] & ok;
      end
    end
  end

  assign len_m1       = eff_len_m1(cfg_i.pattern_length);
  assign window_match = len_hit[len_m1];
  assign window_full  = byte_index_q >= POS_W'(len_m1);
  assign start_pos    = byte_index_q - POS_W'(len_m1);
  assign counted      = window_full && (start_pos >= cfg_i.start_offset) && window_match;
  assign count_inc    = (match_count_q == '1) ? match_count_q : match_count_q + POS_W'(1);
  assign want         = (cfg_i.occurrence == '0) ? POS_W'(1) : cfg_i.occurrence;
  assign hit          = counted && (count_inc >= want);
  assign index_inc    = (byte_index_q == '1) ? byte_index_q : byte_index_q + POS_W'(1);
  assign emit         = !reported_q && (hit || last_i);

  assign advance_o = !(out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_PATTERN - 1; k++) begin
        win_q[k] <= '0;
      end
      byte_index_q  <= '0;
      match_count_q <= '0;
      reported_q    <= 1'b0;
    end else if (fire_i) begin
      if (last_i) begin
        for (int k = 0; k < MAX_PATTERN - 1; k++) begin
          win_q[k] <= '0;
        end
        byte_index_q  <= '0;
        match_count_q <= '0;
        reported_q    <= 1'b0;
      end else if (!reported_q) begin
        for (int k = 0; k < MAX_PATTERN - 1; k++) begin
          win_q[k] <= win_new[k];
        end
        byte_index_q <= index_inc;
        if (counted) begin
          match_count_q <= count_inc;
        end
        if (hit) begin
          reported_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire_i && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && emit) begin
      found_q    <= hit;
      position_q <= hit ? start_pos : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign position_o  = position_q;

endmodule

FILE: rtl/wildcard_byte_pattern_search.sv
// A result passes from the input register, once its request is accepted, through
// the compare into the result register.
// Throughput: one byte per cycle; the input stalls only while a result waits.
// Reset (rst_ni low, asynchronous) clears the window, counters and all valid
// flags, and loads the registers with length one, occurrence one, others zero.
module wildcard_byte_pattern_search import wbps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              found_o,
  output logic [POS_W-1:0]  position_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg;
  logic       s1_valid_q;
  logic [7:0] s1_data_q;
  logic       s1_last_q;
  logic       advance;
  logic       fire;
  logic       accept;

  wbps_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign fire       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_data_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  wbps_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .fire_i      (fire),
    .data_i      (s1_data_q),
    .last_i      (s1_last_q),
    .out_stall_i (out_stall_i),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .found_o     (found_o),
    .position_o  (position_o)
  );

endmodule

FILE: rtl/wbps_checker.sv
module wbps_checker import wbps_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              found_o,
  input logic [POS_W-1:0]  position_o
);

  // A waiting result holds still until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(found_o) && $stable(position_o))
    else $error("stalled result changed");

  // A miss always reports position zero.
  a_miss_zero: assert property (@(posedge clk_i)
    out_valid_o && !found_o |-> position_o == '0)
    else $error("miss result with nonzero position");

  // The input only stalls while the output side is stalled.
  a_stall_cause: assert property (@(posedge clk_i)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled without output backpressure");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid after reset");

endmodule

bind wildcard_byte_pattern_search wbps_checker u_chk (.*);
